// File: design/qks_pkg.sv
// ----------------------------------------------------------------------------
// Quadrant keypoint selector package
// Shared constants, register indexes, quadrant codes, beat types and the
// distance helpers used by the front and back parts of the selector.
// ----------------------------------------------------------------------------
package qks_pkg;

	localparam int CAMERA_COUNT = 4;
	localparam int SLOTS        = 5;
	localparam int TAG_W        = 16;
	localparam int POS_W        = 16;
	localparam int SIZE_W       = 13;
	localparam int CAM_IN_W     = 4;
	localparam int QUAD_W       = 2;
	localparam int AREA_W       = 2 * POS_W;
	localparam int CAM_IDX_W    = (CAMERA_COUNT > 1) ? $clog2(CAMERA_COUNT) : 1;
	localparam int SLOT_IDX_W   = $clog2(SLOTS);
	localparam int CFG_IDX_W    = 8;
	localparam int CFG_DATA_W   = 16;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

	localparam logic [SIZE_W-1:0] IMAGE_WIDTH_RST  = SIZE_W'(640);
	localparam logic [SIZE_W-1:0] IMAGE_HEIGHT_RST = SIZE_W'(480);

	// Quadrant codes; right means x >= cx, lower means y >= cy.
	localparam logic [QUAD_W-1:0] QUAD_RIGHT_LOWER = 2'd0;
	localparam logic [QUAD_W-1:0] QUAD_RIGHT_UPPER = 2'd1;
	localparam logic [QUAD_W-1:0] QUAD_LEFT_UPPER  = 2'd2;
	localparam logic [QUAD_W-1:0] QUAD_LEFT_LOWER  = 2'd3;

	// One classified offer as it waits in the queue.
	typedef struct packed {
		logic                 frame_start;
		logic                 bad_camera;
		logic [CAM_IDX_W-1:0] cam;
		logic [QUAD_W-1:0]    quadrant;
		logic [POS_W-1:0]     cheb;
		logic [AREA_W-1:0]    area;
		logic [TAG_W-1:0]     tag;
		logic [POS_W-1:0]     pos_x;
		logic [POS_W-1:0]     pos_y;
	} qks_item_t;

	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic [POS_W-1:0] pos_x;
		logic [POS_W-1:0] pos_y;
	} qks_slot_t;

	typedef struct packed {
		logic              bad_camera;
		logic              center_taken;
		logic [QUAD_W-1:0] quadrant;
		logic              quadrant_taken;
		logic [SLOTS-1:0]  occupied_mask;
		logic [TAG_W-1:0]  slot0_tag;
		logic [TAG_W-1:0]  slot1_tag;
		logic [TAG_W-1:0]  slot2_tag;
		logic [TAG_W-1:0]  slot3_tag;
		logic [TAG_W-1:0]  slot4_tag;
	} qks_result_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qks_queue_status_t;

	function automatic logic [POS_W-1:0] abs_diff(input logic [POS_W-1:0] a,
		input logic [POS_W-1:0] b);
		return (a >= b) ? (a - b) : (b - a);
	endfunction

	function automatic logic [POS_W-1:0] cheb_dist(input logic [POS_W-1:0] x,
		input logic [POS_W-1:0] y, input logic [POS_W-1:0] cx,
		input logic [POS_W-1:0] cy);
		logic [POS_W-1:0] dx;
		logic [POS_W-1:0] dy;
		dx = abs_diff(x, cx);
		dy = abs_diff(y, cy);
		return (dx > dy) ? dx : dy;
	endfunction

endpackage

// File: design/qks_offer_if.sv
// ----------------------------------------------------------------------------
// Offer channel
// Valid/ready channel carrying one feature offer per beat.
// ----------------------------------------------------------------------------
interface qks_offer_if import qks_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                frame_start;
	logic [CAM_IN_W-1:0] camera_index;
	logic [POS_W-1:0]    pos_x;
	logic [POS_W-1:0]    pos_y;
	logic [TAG_W-1:0]    feature_tag;

	modport source (output valid, frame_start, camera_index, pos_x, pos_y, feature_tag,
		input ready);
	modport sink (input valid, frame_start, camera_index, pos_x, pos_y, feature_tag,
		output ready);
endinterface

// File: design/qks_result_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying the slot state of one camera per beat.
// ----------------------------------------------------------------------------
interface qks_result_if import qks_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              bad_camera;
	logic              center_taken;
	logic [QUAD_W-1:0] quadrant;
	logic              quadrant_taken;
	logic [SLOTS-1:0]  occupied_mask;
	logic [TAG_W-1:0]  slot0_tag;
	logic [TAG_W-1:0]  slot1_tag;
	logic [TAG_W-1:0]  slot2_tag;
	logic [TAG_W-1:0]  slot3_tag;
	logic [TAG_W-1:0]  slot4_tag;

	modport source (output valid, bad_camera, center_taken, quadrant, quadrant_taken,
		occupied_mask, slot0_tag, slot1_tag, slot2_tag, slot3_tag, slot4_tag,
		input ready);
	modport sink (input valid, bad_camera, center_taken, quadrant, quadrant_taken,
		occupied_mask, slot0_tag, slot1_tag, slot2_tag, slot3_tag, slot4_tag,
		output ready);
endinterface

// File: design/qks_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data per beat.
// ----------------------------------------------------------------------------
interface qks_cfg_if import qks_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: design/qks_front.sv
// ----------------------------------------------------------------------------
// Selector front end
// Accepts offers, checks the camera number, finds the quadrant and computes
// the Chebyshev distance and the quadrant product against the image centre.
// ----------------------------------------------------------------------------
module qks_front import qks_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	qks_offer_if.sink        offer,
	input  logic [POS_W-1:0] cx,
	input  logic [POS_W-1:0] cy,
	output qks_item_t        item,
	output logic             item_valid,
	input  logic             item_ready
);

	logic             v_s1;
	qks_item_t        item_s1;
	logic [POS_W-1:0] dx;
	logic [POS_W-1:0] dy;
	logic             right;
	logic             lower;
	logic [QUAD_W-1:0] quad;

	assign offer.ready = !v_s1 || item_ready;

	always_comb begin
		dx    = abs_diff(offer.pos_x, cx);
		dy    = abs_diff(offer.pos_y, cy);
		right = offer.pos_x >= cx;
		lower = offer.pos_y >= cy;
		if (right) begin
			quad = lower ? QUAD_RIGHT_LOWER : QUAD_RIGHT_UPPER;
		end else begin
			quad = lower ? QUAD_LEFT_LOWER : QUAD_LEFT_UPPER;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (offer.ready) begin
			v_s1 <= offer.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (offer.valid && offer.ready) begin
			item_s1.frame_start <= offer.frame_start;
			item_s1.bad_camera  <= 32'(offer.camera_index) >= CAMERA_COUNT;
			item_s1.cam         <= CAM_IDX_W'(offer.camera_index);
			item_s1.quadrant    <= quad;
			item_s1.cheb        <= (dx > dy) ? dx : dy;
			item_s1.area        <= AREA_W'(dx) * AREA_W'(dy);
			item_s1.tag         <= offer.feature_tag;
			item_s1.pos_x       <= offer.pos_x;
			item_s1.pos_y       <= offer.pos_y;
		end
	end

	assign item       = item_s1;
	assign item_valid = v_s1;

endmodule

// File: design/qks_queue.sv
// ----------------------------------------------------------------------------
// Selector item queue
// Two-entry queue that decouples the front end from the slot update.
// ----------------------------------------------------------------------------
module qks_queue import qks_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  qks_item_t         push_data,
	input  logic              push_valid,
	output logic              push_ready,
	output qks_item_t         pop_data,
	output logic              pop_valid,
	input  logic              pop_ready,
	output qks_queue_status_t status
);

	qks_item_t  mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign status.full  = count_q == 2'd2;
	assign status.empty = count_q == 2'd0;
	assign push_ready   = !status.full;
	assign pop_valid    = !status.empty;
	assign push         = push_valid && push_ready;
	assign pop          = pop_valid && pop_ready;
	assign pop_data     = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// File: design/qks_back.sv
// ----------------------------------------------------------------------------
// Selector slot update
// Holds the five slots of every camera, decides whether the offer takes the
// centre slot and its quadrant slot, updates them and registers the result.
// ----------------------------------------------------------------------------
module qks_back import qks_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  qks_item_t        pop_data,
	input  logic             pop_valid,
	output logic             pop_ready,
	input  logic [POS_W-1:0] cx,
	input  logic [POS_W-1:0] cy,
	qks_result_if.source     result
);

	logic [SLOTS-1:0]      valid_q [CAMERA_COUNT];
	qks_slot_t             slots_q [CAMERA_COUNT][SLOTS];
	logic                  out_v_q;
	qks_result_t           res_q;

	qks_item_t             it;
	logic                  pop;
	logic [SLOT_IDX_W-1:0] qidx;
	logic [SLOTS-1:0]      row_valid;
	qks_slot_t             row [SLOTS];
	qks_slot_t             sel;
	logic [POS_W-1:0]      st_cheb;
	logic [POS_W-1:0]      sdx;
	logic [POS_W-1:0]      sdy;
	logic [AREA_W-1:0]     st_area;
	logic                  ctake;
	logic                  qtake;
	logic [SLOTS-1:0]      new_valid;
	logic [TAG_W-1:0]      tag_out [SLOTS];
	qks_result_t           res_d;

	assign it        = pop_data;
	assign pop_ready = !out_v_q || result.ready;
	assign pop       = pop_valid && pop_ready;
	assign qidx      = SLOT_IDX_W'(it.quadrant) + SLOT_IDX_W'(1);

	always_comb begin
		// A frame start empties every slot before this offer is weighed.
		row_valid = it.frame_start ? '0 : valid_q[it.cam];
		row       = slots_q[it.cam];
		sel       = row[qidx];
		st_cheb   = cheb_dist(row[0].pos_x, row[0].pos_y, cx, cy);
		sdx       = abs_diff(sel.pos_x, cx);
		sdy       = abs_diff(sel.pos_y, cy);
		st_area   = AREA_W'(sdx) * AREA_W'(sdy);
		ctake     = !it.bad_camera && (!row_valid[0] || it.cheb < st_cheb);
		qtake     = !it.bad_camera && (!row_valid[qidx] || it.area > st_area);
		new_valid = row_valid;
		if (ctake) begin
			new_valid[0] = 1'b1;
		end
		if (qtake) begin
			new_valid[qidx] = 1'b1;
		end
		for (int k = 0; k < SLOTS; k++) begin
			if (!new_valid[k] || it.bad_camera) begin
				tag_out[k] = '0;
			end else if ((k == 0 && ctake) || (SLOT_IDX_W'(k) == qidx && qtake)) begin
				tag_out[k] = it.tag;
			end else begin
				tag_out[k] = row[k].tag;
			end
		end
		res_d.bad_camera     = it.bad_camera;
		res_d.center_taken   = ctake;
		res_d.quadrant       = it.bad_camera ? '0 : it.quadrant;
		res_d.quadrant_taken = qtake;
		res_d.occupied_mask  = it.bad_camera ? '0 : new_valid;
		res_d.slot0_tag      = tag_out[0];
		res_d.slot1_tag      = tag_out[1];
		res_d.slot2_tag      = tag_out[2];
		res_d.slot3_tag      = tag_out[3];
		res_d.slot4_tag      = tag_out[4];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CAMERA_COUNT; c++) begin
				valid_q[c] <= '0;
			end
			out_v_q <= 1'b0;
		end else begin
			if (pop) begin
				// The offered camera takes its new row; a frame start empties the others.
				for (int c = 0; c < CAMERA_COUNT; c++) begin
					if (!it.bad_camera && CAM_IDX_W'(c) == it.cam) begin
						valid_q[c] <= new_valid;
					end else if (it.frame_start) begin
						valid_q[c] <= '0;
					end
				end
			end
			if (pop_ready) begin
				out_v_q <= pop_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res_d;
			if (ctake) begin
				slots_q[it.cam][0] <= '{tag: it.tag, pos_x: it.pos_x, pos_y: it.pos_y};
			end
			if (qtake) begin
				slots_q[it.cam][qidx] <= '{tag: it.tag, pos_x: it.pos_x, pos_y: it.pos_y};
			end
		end
	end

	assign result.valid          = out_v_q;
	assign result.bad_camera     = res_q.bad_camera;
	assign result.center_taken   = res_q.center_taken;
	assign result.quadrant       = res_q.quadrant;
	assign result.quadrant_taken = res_q.quadrant_taken;
	assign result.occupied_mask  = res_q.occupied_mask;
	assign result.slot0_tag      = res_q.slot0_tag;
	assign result.slot1_tag      = res_q.slot1_tag;
	assign result.slot2_tag      = res_q.slot2_tag;
	assign result.slot3_tag      = res_q.slot3_tag;
	assign result.slot4_tag      = res_q.slot4_tag;

endmodule

// File: design/quadrant_keypoint_selector_core.sv
// ----------------------------------------------------------------------------
// Quadrant keypoint selector core
// Keeps, per camera, the feature nearest the image centre and the feature
// with the largest quadrant product in each of the four quadrants.
// ----------------------------------------------------------------------------
// Usage:
// Offers arrive on the offer channel, one beat per feature. Every offer
// produces exactly one beat on the result channel, in order, carrying the
// take decisions and the five slot tags of that camera after the update.
// The cfg channel writes image_width (index 0) and image_height (index 1);
// it is always ready and may be written only while the block is idle.
// An accepted offer reaches its result beat through the front end register,
// the two-entry queue and the result register.
// Throughput is one offer per cycle while the receiver takes every beat; the
// slot read, compare and write of a camera row happen in the same cycle, so
// offers for the same camera follow each other back to back.
// When the receiver stalls, the result register holds its beat, the queue
// fills, and offer.ready drops once the front end register is also full.
// Reset empties every slot, flushes the queue and loads 640 by 480.
// ----------------------------------------------------------------------------
module quadrant_keypoint_selector_core import qks_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	qks_offer_if.sink    offer,
	qks_result_if.source result,
	qks_cfg_if.sink      cfg
);

	logic [SIZE_W-1:0] width_q;
	logic [SIZE_W-1:0] height_q;
	logic [POS_W-1:0]  cx;
	logic [POS_W-1:0]  cy;

	qks_item_t         front_item;
	logic              front_valid;
	logic              front_ready;
	qks_item_t         back_item;
	logic              back_valid;
	logic              back_ready;
	qks_queue_status_t q_status;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= IMAGE_WIDTH_RST;
			height_q <= IMAGE_HEIGHT_RST;
		end else if (cfg.valid && cfg.ready) begin
			if (cfg.index == REG_IMAGE_WIDTH) begin
				width_q <= cfg.data[SIZE_W-1:0];
			end else if (cfg.index == REG_IMAGE_HEIGHT) begin
				height_q <= cfg.data[SIZE_W-1:0];
			end
		end
	end

	// Centre in 1/16 pixel units: floor(size/2) shifted into 12.4 form.
	assign cx = {width_q[SIZE_W-1:1], 4'b0000};
	assign cy = {height_q[SIZE_W-1:1], 4'b0000};

	qks_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.offer      (offer),
		.cx         (cx),
		.cy         (cy),
		.item       (front_item),
		.item_valid (front_valid),
		.item_ready (front_ready)
	);

	qks_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_data  (front_item),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.pop_data   (back_item),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.status     (q_status)
	);

	qks_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_data  (back_item),
		.pop_valid (back_valid),
		.pop_ready (back_ready),
		.cx        (cx),
		.cy        (cy),
		.result    (result)
	);

	a_bad_camera_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.bad_camera |->
		!result.center_taken && !result.quadrant_taken && result.occupied_mask == '0)
		else $error("bad camera beat carries a slot update");

	a_center_filled: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.bad_camera |-> result.occupied_mask[0])
		else $error("centre slot empty after a good offer");

	a_taken_implies_occupied: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.quadrant_taken |->
		(result.quadrant == QUAD_RIGHT_LOWER && result.occupied_mask[1]) ||
		(result.quadrant == QUAD_RIGHT_UPPER && result.occupied_mask[2]) ||
		(result.quadrant == QUAD_LEFT_UPPER && result.occupied_mask[3]) ||
		(result.quadrant == QUAD_LEFT_LOWER && result.occupied_mask[4]))
		else $error("quadrant slot taken but not marked occupied");

	a_queue_status: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_status.full && q_status.empty))
		else $error("queue reports full and empty at once");

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Quadrant keypoint selector testbench
// Drives feature offers into the selector and checks every result beat
// against an in-bench model of the per-camera centre and quadrant slots.
// It covers directed corner cases, image size extremes, a long receiver
// hold-off, and random traffic under several idle and stall mixes.
// ----------------------------------------------------------------------------
module tb import qks_pkg::*; ();

	localparam int RESET_CYCLES   = 7;
	localparam int RESULT_LATENCY = 3;
	localparam int SETTLE_CYCLES  = 4 * RESULT_LATENCY;
	localparam int HOLD_CYCLES    = 120;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_REPORTS    = 40;

	// Register indexes that decode to nothing; writes to them must be ignored.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LOW  = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HIGH = {CFG_IDX_W{1'b1}};

	typedef struct packed {
		logic                frame_start;
		logic [CAM_IN_W-1:0] camera;
		logic [POS_W-1:0]    x;
		logic [POS_W-1:0]    y;
		logic [TAG_W-1:0]    tag;
	} feature_offer_t;

	logic clk;
	logic arst_n;

	qks_offer_if  offer_bus ();
	qks_result_if result_bus ();
	qks_cfg_if    cfg_bus ();

	quadrant_keypoint_selector_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.offer  (offer_bus),
		.result (result_bus),
		.cfg    (cfg_bus)
	);

	// Model of the slot store and the image size registers.
	bit               held_valid [CAMERA_COUNT][SLOTS];
	logic [TAG_W-1:0] held_tag   [CAMERA_COUNT][SLOTS];
	logic [POS_W-1:0] held_x     [CAMERA_COUNT][SLOTS];
	logic [POS_W-1:0] held_y     [CAMERA_COUNT][SLOTS];
	logic [SIZE_W-1:0] img_width  = IMAGE_WIDTH_RST;
	logic [SIZE_W-1:0] img_height = IMAGE_HEIGHT_RST;

	qks_result_t pending_results [$];
	int unsigned mismatch_count = 0;
	int unsigned send_idle_pct  = 0;
	int unsigned stall_pct      = 0;
	bit          offer_raised   = 1'b0;
	int unsigned hold_requests  = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [POS_W-1:0] centre_x();
		return {img_width[SIZE_W-1:1], 4'b0000};
	endfunction

	function automatic logic [POS_W-1:0] centre_y();
		return {img_height[SIZE_W-1:1], 4'b0000};
	endfunction

	function automatic logic [POS_W-1:0] gap(input logic [POS_W-1:0] a, input logic [POS_W-1:0] b);
		return (a >= b) ? a - b : b - a;
	endfunction

	function automatic logic [POS_W-1:0] ring_distance(input logic [POS_W-1:0] x,
		input logic [POS_W-1:0] y);
		logic [POS_W-1:0] dx;
		logic [POS_W-1:0] dy;
		dx = gap(x, centre_x());
		dy = gap(y, centre_y());
		return (dx > dy) ? dx : dy;
	endfunction

	function automatic logic [AREA_W-1:0] quad_spread(input logic [POS_W-1:0] x,
		input logic [POS_W-1:0] y);
		logic [AREA_W-1:0] dx;
		logic [AREA_W-1:0] dy;
		dx = AREA_W'(gap(x, centre_x()));
		dy = AREA_W'(gap(y, centre_y()));
		return dx * dy;
	endfunction

	// Applies one offer to the slot model and returns the beat it must produce.
	function automatic qks_result_t select_keypoints(input feature_offer_t o);
		qks_result_t      r;
		logic [TAG_W-1:0] shown [SLOTS];
		logic [QUAD_W-1:0] quad;
		int               cam;
		int               slot;
		r = '0;
		if (o.frame_start)
			foreach (held_valid[c, k]) held_valid[c][k] = 1'b0;
		if (o.camera >= CAMERA_COUNT) begin
			r.bad_camera = 1'b1;
			return r;
		end
		cam = int'(o.camera);
		r.center_taken = !held_valid[cam][0] ||
			ring_distance(o.x, o.y) < ring_distance(held_x[cam][0], held_y[cam][0]);
		if (o.x >= centre_x())
			quad = (o.y >= centre_y()) ? QUAD_RIGHT_LOWER : QUAD_RIGHT_UPPER;
		else
			quad = (o.y >= centre_y()) ? QUAD_LEFT_LOWER : QUAD_LEFT_UPPER;
		slot = 1 + int'(quad);
		r.quadrant = quad;
		r.quadrant_taken = !held_valid[cam][slot] ||
			quad_spread(o.x, o.y) > quad_spread(held_x[cam][slot], held_y[cam][slot]);
		for (int k = 0; k < SLOTS; k++) begin
			if ((k == 0 && r.center_taken) || (k == slot && r.quadrant_taken)) begin
				held_valid[cam][k] = 1'b1;
				held_tag[cam][k]   = o.tag;
				held_x[cam][k]     = o.x;
				held_y[cam][k]     = o.y;
			end
			r.occupied_mask[k] = held_valid[cam][k];
			shown[k] = held_valid[cam][k] ? held_tag[cam][k] : '0;
		end
		r.slot0_tag = shown[0];
		r.slot1_tag = shown[1];
		r.slot2_tag = shown[2];
		r.slot3_tag = shown[3];
		r.slot4_tag = shown[4];
		return r;
	endfunction

	function automatic feature_offer_t make_offer(input logic fs, input logic [CAM_IN_W-1:0] cam,
		input logic [POS_W-1:0] x, input logic [POS_W-1:0] y, input logic [TAG_W-1:0] tag);
		feature_offer_t o;
		o.frame_start = fs;
		o.camera      = cam;
		o.x           = x;
		o.y           = y;
		o.tag         = tag;
		return o;
	endfunction

	// Coordinates cluster around the centre so that ties and replacements are frequent.
	function automatic logic [POS_W-1:0] pick_coord(input logic [POS_W-1:0] centre);
		int unsigned mode;
		mode = $urandom_range(99);
		if (mode < 15)
			return centre;
		else if (mode < 55)
			return POS_W'(int'(centre) + int'($urandom_range(64)) - 32);
		else if (mode < 70)
			return POS_W'(int'(centre) + 16 * (int'($urandom_range(40)) - 20));
		else
			return POS_W'($urandom);
	endfunction

	function automatic feature_offer_t random_offer();
		feature_offer_t o;
		o.frame_start = ($urandom_range(79) == 0);
		if ($urandom_range(9) == 0)
			o.camera = CAM_IN_W'($urandom);
		else
			o.camera = CAM_IN_W'($urandom_range(CAMERA_COUNT - 1));
		o.x   = pick_coord(centre_x());
		o.y   = pick_coord(centre_y());
		o.tag = TAG_W'($urandom);
		return o;
	endfunction

	// Valid stays high after a beat so that back-to-back offers need no toggle.
	task automatic offer_feature(input feature_offer_t o);
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			if (offer_raised) begin
				offer_bus.valid <= 1'b0;
				offer_raised = 1'b0;
			end
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		offer_bus.valid        <= 1'b1;
		offer_bus.frame_start  <= o.frame_start;
		offer_bus.camera_index <= o.camera;
		offer_bus.pos_x        <= o.x;
		offer_bus.pos_y        <= o.y;
		offer_bus.feature_tag  <= o.tag;
		offer_raised = 1'b1;
		do @(posedge clk); while (!offer_bus.ready);
		pending_results.insert(pending_results.size(), select_keypoints(o));
	endtask

	task automatic wait_idle();
		if (offer_raised) begin
			offer_bus.valid <= 1'b0;
			offer_raised = 1'b0;
		end
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= data;
		do @(posedge clk); while (!cfg_bus.ready);
		case (idx)
			REG_IMAGE_WIDTH: begin
				img_width = data[SIZE_W-1:0];
			end
			REG_IMAGE_HEIGHT: begin
				img_height = data[SIZE_W-1:0];
			end
			default: begin
			end
		endcase
	endtask

	// Sizes are only changed with nothing in flight.
	task automatic program_size(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
		input logic [CFG_IDX_W-1:0] spare_idx, input logic [CFG_DATA_W-1:0] spare_data);
		wait_idle();
		write_register(REG_IMAGE_WIDTH, w);
		write_register(REG_IMAGE_HEIGHT, h);
		write_register(spare_idx, spare_data);
		cfg_bus.valid <= 1'b0;
	endtask

	// Runs on the reset sizes, 640 by 480.
	task automatic test_directed();
		logic [POS_W-1:0] cx;
		logic [POS_W-1:0] cy;
		cx = centre_x();
		cy = centre_y();
		// Empty slots take any offer, even one sitting exactly on the centre.
		offer_feature(make_offer(1'b1, 4'd0, cx, cy, 16'h0000));
		// An equal distance and an equal product never replace.
		offer_feature(make_offer(1'b0, 4'd0, cx, cy, 16'h0001));
		offer_feature(make_offer(1'b0, 4'd0, POS_W'(cx - 1), POS_W'(cy - 1), 16'h0002));
		offer_feature(make_offer(1'b0, 4'd0, 16'h0000, 16'h0000, 16'hFFFF));
		offer_feature(make_offer(1'b0, 4'd0, 16'hFFFF, 16'hFFFF, 16'h8001));
		offer_feature(make_offer(1'b0, 4'd0, 16'hFFFF, 16'h0000, 16'h7FFE));
		offer_feature(make_offer(1'b0, 4'd0, 16'h0000, 16'hFFFF, 16'h5555));
		offer_feature(make_offer(1'b0, 4'd0, POS_W'(cx + 1), cy, 16'hAAAA));
		offer_feature(make_offer(1'b0, 4'd3, 16'hFFFF, 16'hFFFF, 16'h0F0F));
		offer_feature(make_offer(1'b0, CAM_IN_W'(CAMERA_COUNT), cx, cy, 16'hF0F0));
		// A bad camera with frame start still clears every slot.
		offer_feature(make_offer(1'b1, 4'hF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		offer_feature(make_offer(1'b0, 4'd0, cx, POS_W'(cy + 1), 16'h0100));
		offer_feature(make_offer(1'b0, 4'd1, POS_W'(cx + 2), POS_W'(cy + 3), 16'h0201));
		offer_feature(make_offer(1'b0, 4'd1, POS_W'(cx + 3), POS_W'(cy + 2), 16'h0202));
		offer_feature(make_offer(1'b0, 4'd1, POS_W'(cx + 3), POS_W'(cy + 3), 16'h0203));
		offer_feature(make_offer(1'b0, 4'd2, POS_W'(cx + 5), cy, 16'h0301));
		offer_feature(make_offer(1'b0, 4'd2, cx, POS_W'(cy - 5), 16'h0302));
		offer_feature(make_offer(1'b0, 4'd2, POS_W'(cx + 4), POS_W'(cy + 4), 16'h0303));
		offer_feature(make_offer(1'b0, 4'd2, POS_W'(cx - 4), POS_W'(cy - 4), 16'h0304));
		offer_feature(make_offer(1'b0, 4'd2, POS_W'(cx - 5), POS_W'(cy + 2), 16'h0305));
	endtask

	task automatic test_size_extremes();
		// A zero size puts the centre at the origin, so every offer is right-lower.
		program_size(16'd0, 16'd0, REG_SPARE_HIGH, 16'hFFFF);
		offer_feature(make_offer(1'b1, 4'd0, 16'h0000, 16'h0000, 16'h1111));
		offer_feature(make_offer(1'b0, 4'd0, 16'hFFFF, 16'hFFFF, 16'h1112));
		offer_feature(make_offer(1'b0, 4'd1, 16'h0010, 16'h0000, 16'h1113));
		// Upper bits beyond the register width are dropped, leaving 8191.
		program_size(16'hFFFF, 16'hFFFF, REG_SPARE_LOW, 16'h0000);
		offer_feature(make_offer(1'b1, 4'd0, 16'd65520, 16'd65519, 16'h2221));
		offer_feature(make_offer(1'b0, 4'd0, 16'hFFFF, 16'hFFFF, 16'h2222));
		offer_feature(make_offer(1'b0, 4'd0, 16'h0000, 16'h0000, 16'h2223));
		offer_feature(make_offer(1'b0, 4'd0, 16'd65519, 16'hFFFF, 16'h2224));
		program_size(16'd1, 16'd1, REG_SPARE_HIGH, 16'h5A5A);
		offer_feature(make_offer(1'b1, 4'd2, 16'h0000, 16'h0000, 16'h3331));
		offer_feature(make_offer(1'b0, 4'd2, 16'h0010, 16'h0010, 16'h3332));
		offer_feature(make_offer(1'b0, 4'd2, 16'h0000, 16'hFFFF, 16'h3333));
		program_size(16'd4096, 16'd4096, REG_SPARE_LOW, 16'hA5A5);
		offer_feature(make_offer(1'b1, 4'd3, 16'd32768, 16'd32768, 16'h4441));
		offer_feature(make_offer(1'b0, 4'd3, 16'd32767, 16'd32767, 16'h4442));
		offer_feature(make_offer(1'b0, 4'd3, 16'h0000, 16'hFFFF, 16'h4443));
		offer_feature(make_offer(1'b0, 4'd3, 16'hFFFF, 16'h0000, 16'h4444));
	endtask

	// The receiver holds off while offers keep coming, so the input side backs up.
	task automatic test_backpressure();
		send_idle_pct = 0;
		stall_pct     = 0;
		hold_requests++;
		repeat (30) offer_feature(random_offer());
		wait_idle();
	endtask

	task automatic test_random_traffic(input int unsigned items, input int unsigned idle_pct,
		input int unsigned stall);
		send_idle_pct = idle_pct;
		stall_pct     = stall;
		repeat (items) offer_feature(random_offer());
		send_idle_pct = 0;
	endtask

	task automatic compare_field(input string field, input logic [TAG_W-1:0] want,
		input logic [TAG_W-1:0] got);
		if (want !== got) begin
			mismatch_count++;
			if (mismatch_count <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
		end
	endtask

	// Result receiver; a hold-off request overrides the random stalls for a while.
	initial begin
		int          hold_left;
		int unsigned hold_served;
		hold_left   = 0;
		hold_served = 0;
		result_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_requests != hold_served) begin
				hold_served = hold_requests;
				hold_left   = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_bus.ready <= 1'b0;
			end else begin
				result_bus.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		qks_result_t want;
		if (arst_n && result_bus.valid && result_bus.ready) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("%0t: result beat with nothing expected, expected none, actual %0h",
						$time, result_bus.slot0_tag);
			end else begin
				want = pending_results.pop_front();
				compare_field("bad_camera", TAG_W'(want.bad_camera),
					TAG_W'(result_bus.bad_camera));
				compare_field("center_taken", TAG_W'(want.center_taken),
					TAG_W'(result_bus.center_taken));
				compare_field("quadrant", TAG_W'(want.quadrant), TAG_W'(result_bus.quadrant));
				compare_field("quadrant_taken", TAG_W'(want.quadrant_taken),
					TAG_W'(result_bus.quadrant_taken));
				compare_field("occupied_mask", TAG_W'(want.occupied_mask),
					TAG_W'(result_bus.occupied_mask));
				compare_field("slot0_tag", want.slot0_tag, result_bus.slot0_tag);
				compare_field("slot1_tag", want.slot1_tag, result_bus.slot1_tag);
				compare_field("slot2_tag", want.slot2_tag, result_bus.slot2_tag);
				compare_field("slot3_tag", want.slot3_tag, result_bus.slot3_tag);
				compare_field("slot4_tag", want.slot4_tag, result_bus.slot4_tag);
			end
		end
	end

	// Ends the run when no beat moves on any channel for too long.
	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((offer_bus.valid && offer_bus.ready) || (result_bus.valid && result_bus.ready) ||
				(cfg_bus.valid && cfg_bus.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		arst_n                 <= 1'b0;
		offer_bus.valid        <= 1'b0;
		offer_bus.frame_start  <= 1'b0;
		offer_bus.camera_index <= '0;
		offer_bus.pos_x        <= '0;
		offer_bus.pos_y        <= '0;
		offer_bus.feature_tag  <= '0;
		cfg_bus.valid          <= 1'b0;
		cfg_bus.index          <= '0;
		cfg_bus.data           <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_size_extremes();
		test_backpressure();
		program_size(16'd640, 16'd480, REG_SPARE_LOW, 16'h0F0F);
		test_random_traffic(445, 0, 0);
		program_size(CFG_DATA_W'($urandom_range(1, 4096)), CFG_DATA_W'($urandom_range(1, 4096)),
			REG_SPARE_HIGH, 16'hF0F0);
		test_random_traffic(445, 60, 0);
		program_size(16'd1, 16'd4096, REG_SPARE_LOW, 16'h3C3C);
		test_random_traffic(445, 0, 60);
		program_size(16'd4096, 16'd1, REG_SPARE_HIGH, 16'hC3C3);
		test_random_traffic(445, 17, 17);
		wait_idle();

		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: filelist.f
design/qks_pkg.sv
design/qks_offer_if.sv
design/qks_result_if.sv
design/qks_cfg_if.sv
design/qks_front.sv
design/qks_queue.sv
design/qks_back.sv
design/quadrant_keypoint_selector_core.sv
tb/tb.sv
